### sv/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg: shared types for the IR pulse-distance frame decoder
// Decode phases, result status codes, register indexes and the state and
// configuration records passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // Widths of the state and configuration fields
  localparam int unsigned TickW  = 11;
  localparam int unsigned BitIdxW = 6;
  localparam int unsigned FrameW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;

  // Decode phases (code 7 is unused and recovers to idle)
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEAD_LOW  = 3'd1,
    PH_LEAD_HIGH = 3'd2,
    PH_BIT_LOW   = 3'd3,
    PH_SAMPLE    = 3'd4,
    PH_BIT_HIGH  = 3'd5,
    PH_TRAIL     = 3'd6
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_LEAD_LOW_TO    = 3'd1,
    ST_LEAD_HIGH_TO   = 3'd2,
    ST_BIT_LOW_TO     = 3'd3,
    ST_BIT_HIGH_TO    = 3'd4,
    ST_COMPL_MISMATCH = 3'd5
  } status_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_LEADER_LOW_LIMIT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEADER_HIGH_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BIT_LOW_LIMIT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_DELAY      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BIT_HIGH_LIMIT    = 3'd4;

  // Register reset values
  localparam logic [10:0] LEADER_LOW_LIMIT_RST  = 11'd1000;
  localparam logic [9:0]  LEADER_HIGH_LIMIT_RST = 10'd500;
  localparam logic [7:0]  BIT_LOW_LIMIT_RST     = 8'd60;
  localparam logic [7:0]  SAMPLE_DELAY_RST      = 8'd60;
  localparam logic [7:0]  BIT_HIGH_LIMIT_RST    = 8'd100;

  // Last bit of the frame
  localparam logic [BitIdxW-1:0] LAST_BIT = 6'd63;

  typedef struct packed {
    logic [10:0] leader_low_limit;
    logic [9:0]  leader_high_limit;
    logic [7:0]  bit_low_limit;
    logic [7:0]  sample_delay;
    logic [7:0]  bit_high_limit;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [TickW-1:0]    tick_count;
    logic [BitIdxW-1:0]  bit_index;
    logic [FrameW-1:0]   frame_shift;
  } dec_state_t;

endpackage

### sv/ir_pulse_distance_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_core: NEC-style IR frame decoder
// Times the leader and decodes 64 pulse-distance bits from one pin sample per
// item, then reports the frame with a status.
// ----------------------------------------------------------------------------
// The block takes one pin sample per cycle while in_stall is low. An accepted
// sample is held in an input register; when the result register can take a
// result, the decode step updates the frame state and, when a frame ends or
// fails, loads the result register. The result register is one item deep:
// while a result waits under out_stall, the input register may still take one
// more sample, then in_stall rises.
module ir_pulse_distance_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  // pin samples
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_pin_level,
  // frame results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_frame_data,
  output logic [2:0]  out_status
);

  irpd_pkg::cfg_t       cfg_r;
  irpd_pkg::dec_state_t state_r;
  irpd_pkg::dec_state_t state_nxt;
  logic                 step_emit;
  irpd_pkg::status_t    step_status;

  logic                 in_valid_r;
  logic                 pin_r;
  logic                 adv;
  logic                 in_take;

  logic                 out_valid_r;
  logic [63:0]          out_frame_data_r;
  irpd_pkg::status_t    out_status_r;

  // Handshake: the decode step runs when a sample is held and the result register can take a result
  assign adv      = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_low_limit  <= irpd_pkg::LEADER_LOW_LIMIT_RST;
      cfg_r.leader_high_limit <= irpd_pkg::LEADER_HIGH_LIMIT_RST;
      cfg_r.bit_low_limit     <= irpd_pkg::BIT_LOW_LIMIT_RST;
      cfg_r.sample_delay      <= irpd_pkg::SAMPLE_DELAY_RST;
      cfg_r.bit_high_limit    <= irpd_pkg::BIT_HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irpd_pkg::REG_LEADER_LOW_LIMIT:  cfg_r.leader_low_limit  <= cfg_wdata;
        irpd_pkg::REG_LEADER_HIGH_LIMIT: cfg_r.leader_high_limit <= cfg_wdata[9:0];
        irpd_pkg::REG_BIT_LOW_LIMIT:     cfg_r.bit_low_limit     <= cfg_wdata[7:0];
        irpd_pkg::REG_SAMPLE_DELAY:      cfg_r.sample_delay      <= cfg_wdata[7:0];
        irpd_pkg::REG_BIT_HIGH_LIMIT:    cfg_r.bit_high_limit    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pin_r <= in_pin_level;
    end
  end

  // Decode step
  irpd_step u_step (
    .cur    (state_r),
    .cfg    (cfg_r),
    .pin    (pin_r),
    .nxt    (state_nxt),
    .emit   (step_emit),
    .status (step_status)
  );

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= irpd_pkg::PH_IDLE;
      state_r.tick_count  <= '0;
      state_r.bit_index   <= '0;
      state_r.frame_shift <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && step_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && step_emit) begin
      out_frame_data_r <= state_nxt.frame_shift;
      out_status_r     <= step_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_data = out_frame_data_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  // Input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

  // Reported status is a defined code
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= irpd_pkg::ST_COMPL_MISMATCH))
    else $error("result status out of range");

  // An ok frame carries complementary byte pairs
  a_ok_compl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == irpd_pkg::ST_OK)) |->
      (((out_frame_data_r[23:16] ^ out_frame_data_r[31:24]) == 8'hFF) &&
       ((out_frame_data_r[39:32] ^ out_frame_data_r[47:40]) == 8'hFF) &&
       ((out_frame_data_r[55:48] ^ out_frame_data_r[63:56]) == 8'hFF)))
    else $error("ok frame fails complement check");

  // Idle keeps counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == irpd_pkg::PH_IDLE) |->
      ((state_r.tick_count == '0) && (state_r.bit_index == '0)))
    else $error("counters not cleared in idle");
`endif

endmodule

### sv/irpd_step.sv
// ----------------------------------------------------------------------------
// irpd_step: one-sample decode step
// Given the decoder state, the registers and one pin sample, produces the
// next state and, when a frame ends or fails, a result with its status.
// ----------------------------------------------------------------------------
module irpd_step (
  input  irpd_pkg::dec_state_t cur,
  input  irpd_pkg::cfg_t       cfg,
  input  logic                 pin,
  output irpd_pkg::dec_state_t nxt,
  output logic                 emit,
  output irpd_pkg::status_t    status
);

  logic [irpd_pkg::TickW-1:0]  tc_inc;
  logic [7:0]                  eff_delay;
  logic [irpd_pkg::FrameW-1:0] frame_set;
  logic                        compl_ok;

  // Shared terms
  assign tc_inc    = cur.tick_count + 11'd1;
  assign eff_delay = (cfg.sample_delay == 8'd0) ? 8'd1 : cfg.sample_delay;
  assign frame_set = cur.frame_shift | ({{(irpd_pkg::FrameW-1){1'b0}}, 1'b1} << cur.bit_index);
  assign compl_ok  = ((cur.frame_shift[23:16] ^ cur.frame_shift[31:24]) == 8'hFF) &&
                     ((cur.frame_shift[39:32] ^ cur.frame_shift[47:40]) == 8'hFF) &&
                     ((cur.frame_shift[55:48] ^ cur.frame_shift[63:56]) == 8'hFF);

  // Next state; a level that ends a phase is also the first sample of the next
  always_comb begin
    nxt    = cur;
    emit   = 1'b0;
    status = irpd_pkg::ST_OK;
    unique case (cur.phase)
      irpd_pkg::PH_IDLE: begin
        if (!pin) begin
          nxt.frame_shift = '0;
          nxt.bit_index   = '0;
          if (cfg.leader_low_limit == 11'd0) begin
            emit           = 1'b1;
            status         = irpd_pkg::ST_LEAD_LOW_TO;
            nxt.tick_count = '0;
          end else begin
            nxt.phase      = irpd_pkg::PH_LEAD_LOW;
            nxt.tick_count = 11'd1;
          end
        end
      end
      irpd_pkg::PH_LEAD_LOW: begin
        if (!pin) begin
          if (cur.tick_count >= cfg.leader_low_limit) begin
            emit   = 1'b1;
            status = irpd_pkg::ST_LEAD_LOW_TO;
          end else begin
            nxt.tick_count = tc_inc;
          end
        end else if (cfg.leader_high_limit == 10'd0) begin
          emit   = 1'b1;
          status = irpd_pkg::ST_LEAD_HIGH_TO;
        end else begin
          nxt.phase      = irpd_pkg::PH_LEAD_HIGH;
          nxt.tick_count = 11'd1;
        end
      end
      irpd_pkg::PH_LEAD_HIGH: begin
        if (pin) begin
          if (cur.tick_count >= {1'b0, cfg.leader_high_limit}) begin
            emit   = 1'b1;
            status = irpd_pkg::ST_LEAD_HIGH_TO;
          end else begin
            nxt.tick_count = tc_inc;
          end
        end else if (cfg.bit_low_limit == 8'd0) begin
          emit   = 1'b1;
          status = irpd_pkg::ST_BIT_LOW_TO;
        end else begin
          nxt.phase      = irpd_pkg::PH_BIT_LOW;
          nxt.tick_count = 11'd1;
        end
      end
      irpd_pkg::PH_BIT_LOW: begin
        if (!pin) begin
          if (cur.tick_count >= {3'b000, cfg.bit_low_limit}) begin
            emit   = 1'b1;
            status = irpd_pkg::ST_BIT_LOW_TO;
          end else begin
            nxt.tick_count = tc_inc;
          end
        end else begin
          nxt.phase      = irpd_pkg::PH_SAMPLE;
          nxt.tick_count = '0;
        end
      end
      irpd_pkg::PH_SAMPLE: begin
        if (tc_inc < {3'b000, eff_delay}) begin
          nxt.tick_count = tc_inc;
        end else if (pin) begin
          // one bit: record it, then time its high
          nxt.frame_shift = frame_set;
          if (cfg.bit_high_limit == 8'd0) begin
            emit   = 1'b1;
            status = irpd_pkg::ST_BIT_HIGH_TO;
          end else begin
            nxt.phase      = irpd_pkg::PH_BIT_HIGH;
            nxt.tick_count = 11'd1;
          end
        end else if (cur.bit_index == irpd_pkg::LAST_BIT) begin
          nxt.phase      = irpd_pkg::PH_TRAIL;
          nxt.tick_count = '0;
          nxt.bit_index  = '0;
        end else begin
          nxt.bit_index = cur.bit_index + 6'd1;
          if (cfg.bit_low_limit == 8'd0) begin
            emit   = 1'b1;
            status = irpd_pkg::ST_BIT_LOW_TO;
          end else begin
            nxt.phase      = irpd_pkg::PH_BIT_LOW;
            nxt.tick_count = 11'd1;
          end
        end
      end
      irpd_pkg::PH_BIT_HIGH: begin
        if (pin) begin
          if (cur.tick_count >= {3'b000, cfg.bit_high_limit}) begin
            emit   = 1'b1;
            status = irpd_pkg::ST_BIT_HIGH_TO;
          end else begin
            nxt.tick_count = tc_inc;
          end
        end else if (cur.bit_index == irpd_pkg::LAST_BIT) begin
          nxt.phase      = irpd_pkg::PH_TRAIL;
          nxt.tick_count = '0;
          nxt.bit_index  = '0;
        end else begin
          nxt.bit_index = cur.bit_index + 6'd1;
          if (cfg.bit_low_limit == 8'd0) begin
            emit   = 1'b1;
            status = irpd_pkg::ST_BIT_LOW_TO;
          end else begin
            nxt.phase      = irpd_pkg::PH_BIT_LOW;
            nxt.tick_count = 11'd1;
          end
        end
      end
      irpd_pkg::PH_TRAIL: begin
        if (tc_inc < {3'b000, eff_delay}) begin
          nxt.tick_count = tc_inc;
        end else begin
          emit   = 1'b1;
          status = compl_ok ? irpd_pkg::ST_OK : irpd_pkg::ST_COMPL_MISMATCH;
        end
      end
      default: begin
        nxt.phase      = irpd_pkg::PH_IDLE;
        nxt.tick_count = '0;
        nxt.bit_index  = '0;
      end
    endcase

    // Any result ends the frame
    if (emit) begin
      nxt.phase      = irpd_pkg::PH_IDLE;
      nxt.tick_count = '0;
      nxt.bit_index  = '0;
    end
  end

endmodule

### dv/tb_ir_pulse_distance_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_frame_decoder_core: self-checking bench for the IR decoder
// Feeds pin samples over the valid/stall input channel and scores each frame
// report against a cycle-free decoder model kept inside the bench. A short
// table of directed samples hits each timeout and the register corner cases.
// Random phases follow with well-formed frames, damaged frames and noise,
// under several sender-gap and receiver-stall mixes and register settings.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_frame_decoder_core;
  import irpd_pkg::*;

  // Register codes the block does not decode
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam int DIR_ROWS = 28;

  typedef struct packed {
    logic [FrameW-1:0] data;
    status_t           status;
  } frame_report_t;

  // One queued pin sample; a typed report overrides the model for that item
  typedef struct packed {
    logic          pin;
    logic          typed;
    frame_report_t want;
  } sample_t;

  typedef enum logic {ROW_CFG, ROW_PIN} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   reg_idx;
    logic [CfgDataW-1:0]  value;
    logic                 pin;
    logic                 typed;
    status_t              status;
    logic [FrameW-1:0]    data;
  } dir_row_t;

  typedef enum int {
    FLAW_NONE, FLAW_LEAD_LOW, FLAW_LEAD_HIGH, FLAW_BIT_LOW, FLAW_BIT_HIGH, FLAW_CUT
  } flaw_e;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_pin_level = 1'b1;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [63:0]         out_frame_data;
  logic [2:0]          out_status;

  // Decoder model: limits and frame state
  logic [10:0]        lim_lead_low = LEADER_LOW_LIMIT_RST;
  logic [9:0]         lim_lead_high = LEADER_HIGH_LIMIT_RST;
  logic [7:0]         lim_bit_low = BIT_LOW_LIMIT_RST;
  logic [7:0]         dly_sample = SAMPLE_DELAY_RST;
  logic [7:0]         lim_bit_high = BIT_HIGH_LIMIT_RST;
  phase_t             dec_phase = PH_IDLE;
  logic [TickW-1:0]   dec_ticks = '0;
  logic [BitIdxW-1:0] dec_bit = '0;
  logic [FrameW-1:0]  dec_frame = '0;

  sample_t       pin_q[$];
  frame_report_t awaited[$];
  sample_t       held = '0;
  int            sender_idle_pct = 0;
  int            stall_pct = 0;
  int            mismatches = 0;
  int            frames_seen = 0;
  int            random_pins = 0;

  // Directed samples: each timeout, zero limits, ignored register codes
  dir_row_t script [DIR_ROWS] = '{
    '{ROW_CFG, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_CFG, REG_LEADER_HIGH_LIMIT, 11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_CFG, REG_BIT_LOW_LIMIT,     11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_CFG, REG_SAMPLE_DELAY,      11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_CFG, REG_BIT_HIGH_LIMIT,    11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_CFG, REG_UNMAPPED_LO,       11'h7FF,  1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_CFG, REG_UNMAPPED_HI,       11'h7FF,  1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b1, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b1, ST_LEAD_LOW_TO, 64'd0},
    '{ROW_CFG, REG_LEADER_LOW_LIMIT,  11'd2,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b1, 1'b1, ST_LEAD_HIGH_TO, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b1, ST_LEAD_LOW_TO, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_CFG, REG_LEADER_HIGH_LIMIT, 11'd3,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b1, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b1, ST_BIT_LOW_TO, 64'd0},
    '{ROW_CFG, REG_BIT_LOW_LIMIT,     11'd2,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b1, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b1, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b1, 1'b1, ST_BIT_HIGH_TO, 64'd1},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0},
    '{ROW_PIN, REG_LEADER_LOW_LIMIT,  11'd0,    1'b0, 1'b0, ST_OK, 64'd0}
  };

  ir_pulse_distance_frame_decoder_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pin_level  (in_pin_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_data(out_frame_data),
    .out_status    (out_status)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("tb_ir_pulse_distance_frame_decoder_core failed");
    $finish;
  end

  // Model: finish one bit; returns 1 when the same sample opens the next bit
  function automatic bit advance_bit();
    dec_ticks = '0;
    if (dec_bit == LAST_BIT) begin
      dec_bit = '0;
      dec_phase = PH_TRAIL;
      return 1'b0;
    end
    dec_bit = dec_bit + 1'b1;
    dec_phase = PH_BIT_LOW;
    return 1'b1;
  endfunction

  // Model: one pin sample in, at most one frame report out
  task automatic decode_sample(input logic pin, output bit emit, output frame_report_t rpt);
    bit         again;
    logic [7:0] dly;
    logic [63:0] f;
    emit = 1'b0;
    again = 1'b1;
    rpt = '0;
    dly = (dly_sample == 8'd0) ? 8'd1 : dly_sample;
    while (again && !emit) begin
      again = 1'b0;
      case (dec_phase)
        PH_IDLE: begin
          if (!pin) begin
            dec_frame = '0;
            dec_bit = '0;
            dec_ticks = '0;
            dec_phase = PH_LEAD_LOW;
            again = 1'b1;
          end
        end
        PH_LEAD_LOW: begin
          if (!pin) begin
            if (dec_ticks >= lim_lead_low) begin
              emit = 1'b1;
              rpt.status = ST_LEAD_LOW_TO;
            end else begin
              dec_ticks = dec_ticks + 1'b1;
            end
          end else begin
            dec_ticks = '0;
            dec_phase = PH_LEAD_HIGH;
            again = 1'b1;
          end
        end
        PH_LEAD_HIGH: begin
          if (pin) begin
            if (dec_ticks >= lim_lead_high) begin
              emit = 1'b1;
              rpt.status = ST_LEAD_HIGH_TO;
            end else begin
              dec_ticks = dec_ticks + 1'b1;
            end
          end else begin
            dec_ticks = '0;
            dec_phase = PH_BIT_LOW;
            again = 1'b1;
          end
        end
        PH_BIT_LOW: begin
          if (!pin) begin
            if (dec_ticks >= lim_bit_low) begin
              emit = 1'b1;
              rpt.status = ST_BIT_LOW_TO;
            end else begin
              dec_ticks = dec_ticks + 1'b1;
            end
          end else begin
            dec_ticks = '0;
            dec_phase = PH_SAMPLE;
          end
        end
        PH_SAMPLE: begin
          dec_ticks = dec_ticks + 1'b1;
          if (dec_ticks >= dly) begin
            if (pin) begin
              dec_frame[dec_bit] = 1'b1;
              dec_ticks = '0;
              dec_phase = PH_BIT_HIGH;
              again = 1'b1;
            end else begin
              again = advance_bit();
            end
          end
        end
        PH_BIT_HIGH: begin
          if (pin) begin
            if (dec_ticks >= lim_bit_high) begin
              emit = 1'b1;
              rpt.status = ST_BIT_HIGH_TO;
            end else begin
              dec_ticks = dec_ticks + 1'b1;
            end
          end else begin
            again = advance_bit();
          end
        end
        PH_TRAIL: begin
          dec_ticks = dec_ticks + 1'b1;
          if (dec_ticks >= dly) begin
            f = dec_frame;
            emit = 1'b1;
            // address, command and extra bytes each travel with their inverse
            if ((f[23:16] ^ f[31:24]) == 8'hFF && (f[39:32] ^ f[47:40]) == 8'hFF &&
                (f[55:48] ^ f[63:56]) == 8'hFF)
              rpt.status = ST_OK;
            else
              rpt.status = ST_COMPL_MISMATCH;
          end
        end
        default: begin
          dec_phase = PH_IDLE;
          dec_ticks = '0;
          dec_bit = '0;
        end
      endcase
    end
    if (emit) begin
      rpt.data = dec_frame;
      dec_phase = PH_IDLE;
      dec_ticks = '0;
      dec_bit = '0;
    end
  endtask

  // Input side: score accepted samples, then present the next one or idle
  always @(posedge clk) begin
    bit            emit;
    frame_report_t rpt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_sample(held.pin, emit, rpt);
        if (held.typed)
          awaited.push_back(held.want);
        else if (emit)
          awaited.push_back(rpt);
      end
      if (!in_valid || !in_stall) begin
        if (pin_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          held = pin_q.pop_front();
          in_valid <= 1'b1;
          in_pin_level <= held.pin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each accepted report with the oldest expectation
  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        frames_seen++;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected report: expected none, actual data=%h status=%0d",
                   $time, out_frame_data, out_status);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (out_frame_data !== want.data) begin
            $display("%0t: frame_data mismatch: expected %h, actual %h",
                     $time, want.data, out_frame_data);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Wait until every sample is in and every report is out, plus pipeline slack
  task automatic wait_quiet();
    do @(negedge clk);
    while (pin_q.size() != 0 || in_valid || awaited.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LEADER_LOW_LIMIT:  lim_lead_low = val[10:0];
      REG_LEADER_HIGH_LIMIT: lim_lead_high = val[9:0];
      REG_BIT_LOW_LIMIT:     lim_bit_low = val[7:0];
      REG_SAMPLE_DELAY:      dly_sample = val[7:0];
      REG_BIT_HIGH_LIMIT:    lim_bit_high = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input int ll, input int lh, input int bl, input int sd, input int bh);
    wait_quiet();
    write_reg(REG_LEADER_LOW_LIMIT, ll);
    write_reg(REG_LEADER_HIGH_LIMIT, lh);
    write_reg(REG_BIT_LOW_LIMIT, bl);
    write_reg(REG_SAMPLE_DELAY, sd);
    write_reg(REG_BIT_HIGH_LIMIT, bh);
  endtask

  task automatic queue_pins(input logic lvl, input int n);
    sample_t s;
    s = '0;
    s.pin = lvl;
    repeat (n) pin_q.push_back(s);
    random_pins += n;
  endtask

  // Mostly short pulses, now and then exactly at the limit
  function automatic int pick_len(input int limit);
    if (limit == 0)
      return 1;
    if ($urandom_range(0, 7) == 0)
      return limit;
    return $urandom_range(1, (limit < 4) ? limit : 4);
  endfunction

  // Frame with random payload, mostly with complementary byte pairs, optionally damaged in one place
  task automatic send_frame(input flaw_e flaw);
    logic [63:0] payload;
    int          d;
    int          bad_bit;
    bit          hit;
    payload = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      payload[31:24] = ~payload[23:16];
      payload[47:40] = ~payload[39:32];
      payload[63:56] = ~payload[55:48];
    end
    d = (dly_sample == 8'd0) ? 1 : int'(dly_sample);
    bad_bit = $urandom_range(0, 63);
    queue_pins(1'b0, (flaw == FLAW_LEAD_LOW) ? int'(lim_lead_low) + 1 : pick_len(lim_lead_low));
    queue_pins(1'b1, (flaw == FLAW_LEAD_HIGH) ? int'(lim_lead_high) + 1 :
                     pick_len(lim_lead_high));
    for (int b = 0; b < 64; b++) begin
      hit = (b == bad_bit);
      if (flaw == FLAW_CUT && hit)
        return;
      queue_pins(1'b0, (flaw == FLAW_BIT_LOW && hit) ? int'(lim_bit_low) + 1 :
                       pick_len(lim_bit_low));
      // rising edge plus the wait up to the sampling point
      queue_pins(1'b1, d);
      if (flaw == FLAW_BIT_HIGH && hit)
        queue_pins(1'b1, int'(lim_bit_high) + 1);
      else if (payload[b])
        queue_pins(1'b1, pick_len(lim_bit_high));
    end
    // trailing gap before the complement check
    queue_pins(1'b0, 1);
    queue_pins(1'b1, d);
  endtask

  // Stimulus
  initial begin
    sample_t s;
    int      phase_no;
    int      pick;
    @(posedge rst_n);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (script[r].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(script[r].reg_idx, script[r].value);
      end else begin
        s.pin = script[r].pin;
        s.typed = script[r].typed;
        s.want.data = script[r].data;
        s.want.status = script[r].status;
        pin_q.push_back(s);
      end
    end
    random_pins = 0;

    // Random phases, each with a gap/stall mix and a register setting
    phase_no = 0;
    while (phase_no < 5 || random_pins < 500 || frames_seen < 40) begin
      wait_quiet();
      case (phase_no % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 88; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 88; end
        default: begin sender_idle_pct = 24; stall_pct = 24; end
      endcase
      if (phase_no == 4) begin
        // largest limits: one long clean frame and one leader overrun
        set_limits(2047, 1023, 255, 255, 255);
        send_frame(FLAW_NONE);
        send_frame(FLAW_LEAD_LOW);
      end else begin
        if (phase_no == 2)
          set_limits(0, 0, 0, 0, 0);
        else
          set_limits($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 4),
                     $urandom_range(0, 4), $urandom_range(1, 4));
        repeat (3) begin
          pick = $urandom_range(0, 9);
          if (pick < 5)
            send_frame(FLAW_NONE);
          else if (pick < 8)
            send_frame(flaw_e'($urandom_range(1, 5)));
          else
            repeat ($urandom_range(5, 40)) queue_pins($urandom_range(0, 1), 1);
        end
      end
      phase_no++;
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb_ir_pulse_distance_frame_decoder_core passed");
    else
      $display("tb_ir_pulse_distance_frame_decoder_core failed");
    $finish;
  end

endmodule

### filelist.f
sv/irpd_pkg.sv
sv/irpd_step.sv
sv/ir_pulse_distance_frame_decoder_core.sv
dv/tb_ir_pulse_distance_frame_decoder_core.sv
